[rtl/muvd_pkg.sv]
// package for the muxed usb video deframer
// holds shared constants, codes and the structs passed between modules; no dependencies
`timescale 1ns / 1ps

package muvd_pkg;

    localparam logic [7:0] SYNC_BYTE         = 8'h47;
    localparam int         PAYLOAD_BYTES_DEF = 180;

    // frame offset arithmetic: 10 bit row times 12 bit line size plus block offset
    localparam int ADDR_BITS = 22;
    localparam int PROD_W    = 22;
    localparam int BLK_W     = 12;
    localparam int POS_W     = 24;
    localparam int FADDR_W   = 22;

    localparam logic [POS_W-1:0] ADDR_MASK =
        (ADDR_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((64'd1 << ADDR_BITS) - 64'd1);

    // message kinds
    localparam logic [2:0] KIND_VIDEO = 3'd1;
    localparam logic [2:0] KIND_AUDIO = 3'd2;
    localparam logic [2:0] KIND_ERROR = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_AUDIO_EN    = 2'd0;
    localparam logic [1:0] CFG_LINE_SIZE   = 2'd1;
    localparam logic [1:0] CFG_IMAGE_BYTES = 2'd2;

    localparam logic [11:0] LINE_SIZE_RST   = 12'd1440;
    localparam logic [22:0] IMAGE_BYTES_RST = 23'd691200;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [BLK_W-1:0]  blk_off;
        logic [2:0]        kind;
    } t_blk_info;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         data;
        logic [FADDR_W-1:0] addr;
        logic               video_write;
        logic               audio_out;
        logic               last;
        logic               out_of_range;
    } t_result;

endpackage

[rtl/muxed_usb_video_deframer.sv]
// top level of the muxed usb video deframer: input and result registers, config registers
// depends on muvd_pkg, muvd_hdr and muvd_pay
`timescale 1ns / 1ps

// Accepts one stream word per cycle while o_in_ready is high and returns one result word per
// payload word; the word passes through the input register and then the result register
// before it is presented. Header words give no result. The header capture runs one 10 x 12
// bit multiply into a register at the sync word, and each payload word then takes one add
// and compare against image_bytes plus the address add, so a word can enter every cycle with
// no gap between blocks. Results wait in an output register; input keeps flowing while that
// register is free or being drained, and header words pass even while a result is stalled.
// The user must write configuration via i_cfg_we/i_cfg_addr/i_cfg_data only while the block is idle (not enforced).
module muxed_usb_video_deframer #(
    parameter int PAYLOAD_BYTES = muvd_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_stream_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2:0]                    o_msg_kind,
    output logic [7:0]                    o_payload_byte,
    output logic [muvd_pkg::FADDR_W-1:0]  o_frame_addr,
    output logic                          o_video_write,
    output logic                          o_audio_out,
    output logic                          o_block_last,
    output logic                          o_out_of_range,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_addr,
    input  logic [22:0]                   i_cfg_data
);

    logic                 r_in_v;
    logic [7:0]           r_in_byte;
    logic                 r_out_v;
    muvd_pkg::t_result    r_out;
    logic                 r_audio_en;
    logic [11:0]          r_line_size;
    logic [22:0]          r_image_bytes;

    logic                 w_adv;
    logic                 w_hunting;
    logic                 w_sync;
    muvd_pkg::t_blk_info  w_info;
    muvd_pkg::t_result    w_result;

    // header words never need the output register
    assign w_adv      = r_in_v && (w_hunting || !r_out_v || i_out_ready);
    assign o_in_ready = !r_in_v || w_adv;

    muvd_hdr #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_hdr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_adv && w_hunting),
        .i_byte      (r_in_byte),
        .i_line_size (r_line_size),
        .o_sync      (w_sync),
        .o_info      (w_info)
    );

    muvd_pay #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_pay (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sync        (w_sync),
        .i_step        (w_adv && !w_hunting),
        .i_byte        (r_in_byte),
        .i_info        (w_info),
        .i_audio_en    (r_audio_en),
        .i_image_bytes (r_image_bytes),
        .o_hunting     (w_hunting),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_in_ready) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_stream_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv && !w_hunting) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && !w_hunting) begin
            r_out <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_audio_en    <= 1'b0;
            r_line_size   <= muvd_pkg::LINE_SIZE_RST;
            r_image_bytes <= muvd_pkg::IMAGE_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                muvd_pkg::CFG_AUDIO_EN:    r_audio_en    <= i_cfg_data[0];
                muvd_pkg::CFG_LINE_SIZE:   r_line_size   <= i_cfg_data[11:0];
                muvd_pkg::CFG_IMAGE_BYTES: r_image_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_msg_kind     = r_out.kind;
    assign o_payload_byte = r_out.data;
    assign o_frame_addr   = r_out.addr;
    assign o_video_write  = r_out.video_write;
    assign o_audio_out    = r_out.audio_out;
    assign o_block_last   = r_out.last;
    assign o_out_of_range = r_out.out_of_range;

`ifndef SYNTHESIS
    // a block outside the frame store never writes video
    a_no_write_when_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_video_write && o_out_of_range))
        else $error("video write on out of range block");

    // out of range results carry the error kind and a zero address
    a_oor_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |->
            (o_msg_kind == muvd_pkg::KIND_ERROR) && (o_frame_addr == '0))
        else $error("out of range result with bad kind or address");

    // last word of a block sends the sequencer back to hunting
    a_last_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_hunting && w_result.last) |=> w_hunting)
        else $error("still in payload after last word");
`endif

endmodule

[rtl/muvd_hdr.sv]
// header hunter: shifts stream words into the header and captures block fields on sync
// depends on muvd_pkg
`timescale 1ns / 1ps

module muvd_hdr #(
    parameter int PAYLOAD_BYTES = muvd_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic [11:0]          i_line_size,
    output logic                 o_sync,
    output muvd_pkg::t_blk_info  o_info
);

    logic [31:0]                  r_hdr;
    logic [31:0]                  n_hdr;
    muvd_pkg::t_blk_info          r_info;
    logic [9:0]                   w_row;
    logic [muvd_pkg::PROD_W-1:0]  w_prod;
    logic [muvd_pkg::BLK_W-1:0]   w_blk_off;

    assign o_sync = i_step && (i_byte == muvd_pkg::SYNC_BYTE);

    // fields are read from r_hdr as it stands when the sync word arrives; the sync word is not shifted in
    assign w_row     = {r_hdr[28:20], r_hdr[19]};
    assign w_prod    = muvd_pkg::PROD_W'(w_row) * muvd_pkg::PROD_W'(i_line_size);
    assign w_blk_off = {8'd0, r_hdr[18:15]} * muvd_pkg::BLK_W'(PAYLOAD_BYTES);

    always_comb begin
        n_hdr = r_hdr;
        if (i_step) begin
            n_hdr = o_sync ? 32'd0 : {i_byte, r_hdr[31:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= 32'd0;
        end else begin
            r_hdr <= n_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_sync) begin
            r_info.prod    <= w_prod;
            r_info.blk_off <= w_blk_off;
            r_info.kind    <= r_hdr[31:29];
        end
    end

    assign o_info = r_info;

endmodule

[rtl/muvd_pay.sv]
// payload sequencer: counts payload words and forms each result
// depends on muvd_pkg
`timescale 1ns / 1ps

module muvd_pay #(
    parameter int PAYLOAD_BYTES = muvd_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_sync,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  muvd_pkg::t_blk_info  i_info,
    input  logic                 i_audio_en,
    input  logic [22:0]          i_image_bytes,
    output logic                 o_hunting,
    output muvd_pkg::t_result    o_result
);

    localparam int CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    logic                        r_in_payload;
    logic [CNT_W-1:0]            r_count;
    logic                        w_last;
    logic                        w_ovf;
    logic [muvd_pkg::POS_W-1:0]  w_pos;
    logic [muvd_pkg::POS_W-1:0]  w_addr_full;
    logic [2:0]                  w_kind;

    assign o_hunting = !r_in_payload;
    assign w_last    = (r_count == CNT_W'(PAYLOAD_BYTES - 1));

    assign w_pos = muvd_pkg::POS_W'(i_info.prod) + muvd_pkg::POS_W'(i_info.blk_off);
    assign w_ovf = (w_pos + muvd_pkg::POS_W'(PAYLOAD_BYTES))
                   > muvd_pkg::POS_W'(i_image_bytes);
    assign w_addr_full = (w_pos + muvd_pkg::POS_W'(r_count)) & muvd_pkg::ADDR_MASK;
    assign w_kind = w_ovf ? muvd_pkg::KIND_ERROR : i_info.kind;

    always_comb begin
        o_result.kind         = w_kind;
        o_result.data         = i_byte;
        o_result.addr         = w_ovf ? '0 : w_addr_full[muvd_pkg::FADDR_W-1:0];
        o_result.video_write  = (w_kind == muvd_pkg::KIND_VIDEO);
        o_result.audio_out    = i_audio_en && ((w_kind == muvd_pkg::KIND_VIDEO) ||
                                               (w_kind == muvd_pkg::KIND_AUDIO));
        o_result.last         = w_last;
        o_result.out_of_range = w_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_count      <= '0;
        end else if (i_sync) begin
            r_in_payload <= 1'b1;
            r_count      <= '0;
        end else if (i_step) begin
            if (w_last) begin
                r_in_payload <= 1'b0;
                r_count      <= '0;
            end else begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

endmodule
